/* hw/rtl/sbc_pkg.sv */
// Shared types, codes and constants for the sprite blit compositor.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

   localparam int SIDE_W      = 11;
   localparam int DEST_SIDE_W = 13;
   localparam int COORD_W     = 12;
   localparam int OFFSET_W    = 28;
   localparam int PIXEL_W     = 32;
   localparam int KEY_W       = 24;
   localparam int PITCH_W     = 16;
   localparam int POS_W       = 16;
   localparam int MODE_W      = 3;
   localparam int PCT_W       = 7;
   localparam int BAR_W       = 17;
   localparam int CLIP_W      = 19;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [SIDE_W-1:0]      MAX_SPRITE_SIDE = 11'd1024;
   localparam logic [DEST_SIDE_W-1:0] MAX_DEST_SIDE   = 13'd4096;
   localparam logic [SIDE_W-1:0]      COUNT_MAX       = 11'd2047;
   localparam logic [PIXEL_W-1:0]     RGB_MASK        = 32'h00ff_ffff;
   localparam logic [BAR_W-1:0]       BAR_SCALE       = 17'd100;

   localparam logic OP_START = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [MODE_W-1:0] MODE_COPY  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_KEYED = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TINT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BLEND = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BAR   = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_PITCH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_KEY   = 3'd5;

   localparam logic [DEST_SIDE_W-1:0] RESET_DEST_WIDTH  = 13'd640;
   localparam logic [DEST_SIDE_W-1:0] RESET_DEST_HEIGHT = 13'd480;
   localparam logic [PITCH_W-1:0]     RESET_DEST_PITCH  = 16'd2560;

   typedef struct packed {
      logic                      operation;
      logic [SIDE_W-1:0]         sprite_width;
      logic [SIDE_W-1:0]         sprite_height;
      logic signed [POS_W-1:0]   hot_x;
      logic signed [POS_W-1:0]   hot_y;
      logic signed [POS_W-1:0]   draw_x;
      logic signed [POS_W-1:0]   draw_y;
      logic [MODE_W-1:0]         draw_mode;
      logic [PCT_W-1:0]          percent;
      logic [PIXEL_W-1:0]        sprite_pixel;
      logic [PIXEL_W-1:0]        background_pixel;
   } sbc_req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  dest_x;
      logic [COORD_W-1:0]  dest_y;
      logic [OFFSET_W-1:0] dest_offset;
      logic [PIXEL_W-1:0]  pixel_out;
   } sbc_rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  camera_x;
      logic signed [POS_W-1:0]  camera_y;
      logic [DEST_SIDE_W-1:0]   dest_width;
      logic [DEST_SIDE_W-1:0]   dest_height;
      logic [PITCH_W-1:0]       dest_pitch;
      logic [KEY_W-1:0]         color_key;
   } sbc_config_type;

   typedef struct packed {
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [PIXEL_W-1:0] pixel_out;
   } sbc_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sbc_queue_status_type;

endpackage

`default_nettype wire

/* hw/rtl/sbc_queue.sv */
// Write queue between the front (classify) and back (address) parts.
// Depends on sbc_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module sbc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  sbc_pkg::sbc_entry_type        push_data,
   input  logic                          pop,
   output sbc_pkg::sbc_entry_type        head,
   output sbc_pkg::sbc_queue_status_type status
);
   import sbc_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   sbc_entry_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

/* hw/rtl/sbc_front.sv */
// Front part: accepts beats, clips start commands over four stages and
// classifies pixel beats into queue writes. Depends on sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sbc_pkg::sbc_req_type          req_payload,
   input  sbc_pkg::sbc_config_type       cfg,
   input  sbc_pkg::sbc_queue_status_type queue_status,
   output logic                          push,
   output sbc_pkg::sbc_entry_type        push_data
);
   import sbc_pkg::*;

   localparam int AXES   = 2;
   localparam int STAGES = 4;

   logic accept, is_start, is_pixel, busy, commit;
   logic [STAGES-1:0] stage_ff, stage_in;

   logic signed [CLIP_W-1:0] org_ff [AXES], org_in [AXES];
   logic signed [CLIP_W-1:0] cam_ff [AXES], cam_in [AXES];
   logic [SIDE_W-1:0]        size_ff [AXES], size_in [AXES];
   logic [DEST_SIDE_W-1:0]   span_ff [AXES], span_in [AXES];
   logic [MODE_W-1:0]        start_mode_ff;
   logic [PCT_W-1:0]         pct_ff;

   logic signed [CLIP_W-1:0] diff_ff [AXES], diff_in [AXES];
   logic signed [CLIP_W-1:0] cut_ff [AXES], cut_in [AXES];
   logic signed [CLIP_W-1:0] len1_ff [AXES], len1_in [AXES];
   logic signed [CLIP_W-1:0] rem_ff [AXES], rem_in [AXES];
   logic signed [CLIP_W-1:0] start_ff [AXES], start_in [AXES];
   logic signed [CLIP_W-1:0] len_ff [AXES], len_in [AXES];
   logic                     vis;

   logic [SIDE_W-1:0]  full_width_ff, full_width_in;
   logic [SIDE_W-1:0]  clip_left_ff, clip_left_in;
   logic [SIDE_W:0]    clip_right_ff, clip_right_in;
   logic [SIDE_W-1:0]  clip_top_ff, clip_top_in;
   logic [SIDE_W:0]    clip_bottom_ff, clip_bottom_in;
   logic [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic [COORD_W-1:0] origin_y_ff, origin_y_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [BAR_W-1:0]   bar_limit_ff, bar_limit_in;
   logic [SIDE_W-1:0]  col_ff, col_in;
   logic [SIDE_W-1:0]  row_ff, row_in;

   logic               step, in_win, keyed, bar_ok, pass;
   logic [SIDE_W-1:0]  vcol, vrow;
   logic [SIDE_W:0]    col_inc;
   logic [PIXEL_W-1:0] spr, bg, pix;

   assign busy      = |stage_ff;
   assign commit    = stage_ff[STAGES-1];
   assign req_stall = busy || queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign is_start  = (req_payload.operation == OP_START);
   assign is_pixel  = (req_payload.operation == OP_PIXEL);
   assign stage_in  = {stage_ff[STAGES-2:0], accept && is_start};

   // start command: capture, then clip each axis
   always_comb begin
      logic [SIDE_W-1:0]      sw, sh;
      logic [DEST_SIDE_W-1:0] dw, dh;
      logic                   lt;
      logic signed [CLIP_W-1:0] size_ext, span_ext;
      sw = (req_payload.sprite_width > MAX_SPRITE_SIDE) ? MAX_SPRITE_SIDE
                                                        : req_payload.sprite_width;
      sh = (req_payload.sprite_height > MAX_SPRITE_SIDE) ? MAX_SPRITE_SIDE
                                                         : req_payload.sprite_height;
      dw = (cfg.dest_width > MAX_DEST_SIDE) ? MAX_DEST_SIDE : cfg.dest_width;
      dh = (cfg.dest_height > MAX_DEST_SIDE) ? MAX_DEST_SIDE : cfg.dest_height;
      org_in[0]  = $signed({{3{req_payload.draw_x[POS_W-1]}}, req_payload.draw_x})
                 - $signed({{3{req_payload.hot_x[POS_W-1]}}, req_payload.hot_x});
      org_in[1]  = $signed({{3{req_payload.draw_y[POS_W-1]}}, req_payload.draw_y})
                 - $signed({{3{req_payload.hot_y[POS_W-1]}}, req_payload.hot_y});
      cam_in[0]  = $signed({{3{cfg.camera_x[POS_W-1]}}, cfg.camera_x});
      cam_in[1]  = $signed({{3{cfg.camera_y[POS_W-1]}}, cfg.camera_y});
      size_in[0] = sw;
      size_in[1] = sh;
      span_in[0] = dw;
      span_in[1] = dh;
      for (int a = 0; a < AXES; a++) begin
         diff_in[a]  = cam_ff[a] - org_ff[a];
         lt          = !diff_ff[a][CLIP_W-1] && (diff_ff[a] != '0);
         size_ext    = $signed({8'd0, size_ff[a]});
         span_ext    = $signed({6'd0, span_ff[a]});
         cut_in[a]   = lt ? diff_ff[a] : '0;
         len1_in[a]  = size_ext - (lt ? diff_ff[a] : '0);
         rem_in[a]   = lt ? span_ext : span_ext + diff_ff[a];
         start_in[a] = lt ? '0 : -diff_ff[a];
         len_in[a]   = (len1_ff[a] >= rem_ff[a]) ? rem_ff[a] : len1_ff[a];
      end
      vis = !len_ff[0][CLIP_W-1] && (len_ff[0] != '0)
         && !len_ff[1][CLIP_W-1] && (len_ff[1] != '0);
   end

   always_ff @(posedge clock) begin
      if (accept && is_start) begin
         org_ff        <= org_in;
         cam_ff        <= cam_in;
         size_ff       <= size_in;
         span_ff       <= span_in;
         start_mode_ff <= req_payload.draw_mode;
         pct_ff        <= req_payload.percent;
      end
      diff_ff  <= diff_in;
      cut_ff   <= cut_in;
      len1_ff  <= len1_in;
      rem_ff   <= rem_in;
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   // pixel beat: window test, key test and composition
   always_comb begin
      spr     = req_payload.sprite_pixel;
      bg      = req_payload.background_pixel;
      step    = accept && is_pixel && (full_width_ff != '0);
      col_inc = {1'b0, col_ff} + (SIDE_W + 1)'(1);
      in_win  = (col_ff >= clip_left_ff) && ({1'b0, col_ff} < clip_right_ff)
             && (row_ff >= clip_top_ff) && ({1'b0, row_ff} < clip_bottom_ff);
      vcol    = col_ff - clip_left_ff;
      vrow    = row_ff - clip_top_ff;
      keyed   = ((spr & RGB_MASK) == {8'd0, cfg.color_key});
      bar_ok  = ((BAR_W'(vcol) * BAR_SCALE) < bar_limit_ff);
      pix     = spr;
      case (mode_ff)
         MODE_COPY: begin
            pass = 1'b1;
         end
         MODE_KEYED: begin
            pass = !keyed;
         end
         MODE_TINT: begin
            pass = !keyed;
            pix  = {bg[31:24], spr[23:16], 1'b0, spr[15:9], 1'b0, spr[7:1]};
         end
         MODE_BLEND: begin
            pass = !keyed;
            pix  = {bg[31:24],
                    {1'b0, spr[23:17]} + {1'b0, bg[23:17]},
                    {1'b0, spr[15:9]} + {1'b0, bg[15:9]},
                    {1'b0, spr[7:1]} + {1'b0, bg[7:1]}};
         end
         MODE_BAR: begin
            pass = !keyed && bar_ok;
         end
         default: begin
            pass = 1'b0;
         end
      endcase
      push                = step && in_win && pass;
      push_data.dest_x    = origin_x_ff + {1'b0, vcol};
      push_data.dest_y    = origin_y_ff + {1'b0, vrow};
      push_data.pixel_out = pix;
   end

   // latched draw state and raster position
   always_comb begin
      full_width_in  = full_width_ff;
      clip_left_in   = clip_left_ff;
      clip_right_in  = clip_right_ff;
      clip_top_in    = clip_top_ff;
      clip_bottom_in = clip_bottom_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      mode_in        = mode_ff;
      bar_limit_in   = bar_limit_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      if (commit) begin
         full_width_in = size_ff[0];
         mode_in       = start_mode_ff;
         col_in        = '0;
         row_in        = '0;
         if (vis) begin
            clip_left_in   = cut_ff[0][SIDE_W-1:0];
            clip_right_in  = cut_ff[0][SIDE_W:0] + len_ff[0][SIDE_W:0];
            clip_top_in    = cut_ff[1][SIDE_W-1:0];
            clip_bottom_in = cut_ff[1][SIDE_W:0] + len_ff[1][SIDE_W:0];
            origin_x_in    = start_ff[0][COORD_W-1:0];
            origin_y_in    = start_ff[1][COORD_W-1:0];
            bar_limit_in   = BAR_W'(pct_ff) * BAR_W'(len_ff[0][SIDE_W-1:0]);
         end else begin
            clip_left_in   = '0;
            clip_right_in  = '0;
            clip_top_in    = '0;
            clip_bottom_in = '0;
            origin_x_in    = '0;
            origin_y_in    = '0;
            bar_limit_in   = '0;
         end
      end else if (step) begin
         if (col_inc >= {1'b0, full_width_ff}) begin
            col_in = '0;
            if (row_ff < COUNT_MAX) begin
               row_in = row_ff + SIDE_W'(1);
            end
         end else begin
            col_in = col_inc[SIDE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff       <= '0;
         full_width_ff  <= '0;
         clip_left_ff   <= '0;
         clip_right_ff  <= '0;
         clip_top_ff    <= '0;
         clip_bottom_ff <= '0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         mode_ff        <= MODE_COPY;
         bar_limit_ff   <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
      end else begin
         stage_ff       <= stage_in;
         full_width_ff  <= full_width_in;
         clip_left_ff   <= clip_left_in;
         clip_right_ff  <= clip_right_in;
         clip_top_ff    <= clip_top_in;
         clip_bottom_ff <= clip_bottom_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         mode_ff        <= mode_in;
         bar_limit_ff   <= bar_limit_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sbc_back.sv */
// Back part: pops queued writes, forms the byte offset and holds the
// result beat in the output register. Depends on sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sbc_pkg::sbc_queue_status_type queue_status,
   input  sbc_pkg::sbc_entry_type        head,
   input  logic [sbc_pkg::PITCH_W-1:0]   dest_pitch,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sbc_pkg::sbc_rsp_type          rsp_payload
);
   import sbc_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   sbc_rsp_type rsp_payload_ff, rsp_payload_in;

   always_comb begin
      pop          = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
      rsp_payload_in.dest_x      = head.dest_x;
      rsp_payload_in.dest_y      = head.dest_y;
      rsp_payload_in.dest_offset = ({16'd0, head.dest_y} * {12'd0, dest_pitch})
                                 + {14'd0, head.dest_x, 2'b00};
      rsp_payload_in.pixel_out   = head.pixel_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* hw/rtl/sprite_blit_compositor_unit.sv */
// Top level of the sprite blit compositor: control registers, front,
// write queue and back. Depends on sbc_pkg, sbc_front, sbc_queue, sbc_back.
//
// Usage: program camera_x/y, dest_width/height, dest_pitch and color_key
// through the csr_ port while idle. Send a start beat (operation 0), then
// one pixel beat (operation 1) per sprite pixel in raster order, each with
// the background pixel at its mapped place. Each visible pixel its draw mode
// passes yields one rsp_ beat with coordinates, byte offset and pixel value.
// Throughput: one pixel beat per cycle while the write queue is not full.
// A start beat raises req_stall while the clip pipeline works on it,
// after which pixels flow again. A taken pixel that passes is written
// into the four-entry write queue, then into the output register that
// presents its result beat.
// When the receiver stalls, the output register holds its beat and the
// queue fills; req_stall rises once the queue is full.
// Reset (synchronous, active high) restores register defaults, clears the
// queue and the draw state; no clearing pass, beats are taken next cycle.
`timescale 1ns / 1ps
`default_nettype none

module sprite_blit_compositor_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sbc_pkg::sbc_req_type               req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sbc_pkg::sbc_rsp_type               rsp_payload,
   input  logic                               csr_write_enable,
   input  logic [sbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sbc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sbc_pkg::*;

   sbc_config_type       cfg_ff, cfg_in;
   sbc_queue_status_type queue_status;
   sbc_entry_type        push_data, head;
   logic                 push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CAMERA_X:    cfg_in.camera_x    = csr_data[POS_W-1:0];
            CSR_CAMERA_Y:    cfg_in.camera_y    = csr_data[POS_W-1:0];
            CSR_DEST_WIDTH:  cfg_in.dest_width  = csr_data[DEST_SIDE_W-1:0];
            CSR_DEST_HEIGHT: cfg_in.dest_height = csr_data[DEST_SIDE_W-1:0];
            CSR_DEST_PITCH:  cfg_in.dest_pitch  = csr_data[PITCH_W-1:0];
            CSR_COLOR_KEY:   cfg_in.color_key   = csr_data[KEY_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x    <= '0;
         cfg_ff.camera_y    <= '0;
         cfg_ff.dest_width  <= RESET_DEST_WIDTH;
         cfg_ff.dest_height <= RESET_DEST_HEIGHT;
         cfg_ff.dest_pitch  <= RESET_DEST_PITCH;
         cfg_ff.color_key   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   sbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   sbc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head         (head),
      .dest_pitch   (cfg_ff.dest_pitch),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire

/* hw/rtl/sbc_checker.sv */
// Port-level checks for the sprite blit compositor and their bind.
// Depends on sbc_pkg and the sprite_blit_compositor_unit ports.
`timescale 1ns / 1ps
`default_nettype none

module sbc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input sbc_pkg::sbc_req_type  req_payload,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input sbc_pkg::sbc_rsp_type  rsp_payload
);
   import sbc_pkg::*;

   // hold a stalled result beat
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   // drop any pending result on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // block new beats while a start command is clipped
   a_start_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.operation == OP_START) |=> req_stall)
      else $error("beat accepted during start clipping");

endmodule

bind sprite_blit_compositor_unit sbc_checker u_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for sprite_blit_compositor_unit: a directed script of
// draw commands, then randomized sprite draws under several window settings.
// Depends on sbc_pkg and the block's RTL only; results come from an in-bench blit predictor.
`timescale 1ns / 1ps

module tb_top;
   import sbc_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam logic [MODE_W-1:0] MODE_UNKNOWN_LAST = 3'd7;

   typedef struct {
      sbc_req_type beat;
      bit          known;
      bit          writes;
      sbc_rsp_type golden;
   } script_row_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   sbc_req_type             req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   sbc_rsp_type             rsp_payload;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_CAMERA_X;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // window settings as the block holds them
   logic signed [POS_W-1:0] cam_x = '0;
   logic signed [POS_W-1:0] cam_y = '0;
   logic [DEST_SIDE_W-1:0]  dst_w = RESET_DEST_WIDTH;
   logic [DEST_SIDE_W-1:0]  dst_h = RESET_DEST_HEIGHT;
   logic [PITCH_W-1:0]      pitch = RESET_DEST_PITCH;
   logic [KEY_W-1:0]        key = '0;

   // latched draw command and raster position
   logic [16:0]             org_x = '0;
   logic [16:0]             org_y = '0;
   logic [SIDE_W-1:0]       skip_x = '0;
   logic [SIDE_W-1:0]       skip_y = '0;
   logic [SIDE_W-1:0]       vis_w = '0;
   logic [SIDE_W-1:0]       vis_h = '0;
   logic [SIDE_W-1:0]       spr_w = '0;
   logic [MODE_W-1:0]       cur_mode = MODE_COPY;
   logic [BAR_W-1:0]        bar_lim = '0;
   logic [SIDE_W-1:0]       col_n = '0;
   logic [SIDE_W-1:0]       row_n = '0;

   sbc_rsp_type             pending_writes[$];
   script_row_type          script[$];
   bit                      quiet = 1'b0;
   int                      error_count = 0;
   int                      beat_count = 0;
   int                      start_count = 0;
   int                      write_count = 0;
   int                      setting_count = 1;
   int                      idle_cycles = 0;

   sprite_blit_compositor_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_wait();
      return quiet ? 0 : int'($urandom_range(0, 15));
   endfunction

   function automatic sbc_req_type start_beat(input int w, input int h, input int hx,
                                              input int hy, input int dx, input int dy,
                                              input logic [MODE_W-1:0] mode, input int pct);
      sbc_req_type b;
      b = '0;
      b.operation = OP_START;
      b.sprite_width = SIDE_W'(w);
      b.sprite_height = SIDE_W'(h);
      b.hot_x = POS_W'(hx);
      b.hot_y = POS_W'(hy);
      b.draw_x = POS_W'(dx);
      b.draw_y = POS_W'(dy);
      b.draw_mode = mode;
      b.percent = PCT_W'(pct);
      return b;
   endfunction

   function automatic sbc_req_type pixel_beat(input logic [PIXEL_W-1:0] spr,
                                              input logic [PIXEL_W-1:0] bg);
      sbc_req_type b;
      b = '0;
      b.operation = OP_PIXEL;
      b.sprite_pixel = spr;
      b.background_pixel = bg;
      return b;
   endfunction

   function automatic sbc_rsp_type make_write(input int x, input int y, input int off,
                                              input logic [PIXEL_W-1:0] pix);
      sbc_rsp_type w;
      w.dest_x = COORD_W'(x);
      w.dest_y = COORD_W'(y);
      w.dest_offset = OFFSET_W'(off);
      w.pixel_out = pix;
      return w;
   endfunction

   function automatic logic [SIDE_W-1:0] clip_span(input longint org, input longint len,
                                                   input longint cam, input longint span,
                                                   output logic [SIDE_W-1:0] skip,
                                                   output logic [16:0] start);
      longint cut;
      longint pos;
      cut = 0;
      pos = org;
      if (pos < cam) begin
         cut = cam - pos;
         len = len - cut;
         pos = cam;
      end
      if (pos + len >= cam + span) len = cam + span - pos;
      if (len <= 0) begin
         skip = '0;
         start = '0;
         return '0;
      end
      skip = SIDE_W'(cut);
      start = 17'(pos - cam);
      return SIDE_W'(len);
   endfunction

   function automatic bit compose_write(input sbc_req_type b, output sbc_rsp_type w);
      longint sw, sh, dw, dh, ox, oy;
      int col, row, vcol;
      logic [PIXEL_W-1:0] spr, bg, pix;
      logic [COORD_W-1:0] dx, dy;
      bit keyed;
      w = '0;
      if (b.operation == OP_START) begin
         sw = (b.sprite_width > MAX_SPRITE_SIDE) ? MAX_SPRITE_SIDE : b.sprite_width;
         sh = (b.sprite_height > MAX_SPRITE_SIDE) ? MAX_SPRITE_SIDE : b.sprite_height;
         dw = (dst_w > MAX_DEST_SIDE) ? MAX_DEST_SIDE : dst_w;
         dh = (dst_h > MAX_DEST_SIDE) ? MAX_DEST_SIDE : dst_h;
         ox = longint'($signed(b.draw_x)) - longint'($signed(b.hot_x));
         oy = longint'($signed(b.draw_y)) - longint'($signed(b.hot_y));
         vis_w = clip_span(ox, sw, longint'(cam_x), dw, skip_x, org_x);
         vis_h = clip_span(oy, sh, longint'(cam_y), dh, skip_y, org_y);
         if (vis_w == 0 || vis_h == 0) begin
            vis_w = '0;
            vis_h = '0;
            skip_x = '0;
            skip_y = '0;
            org_x = '0;
            org_y = '0;
         end
         spr_w = SIDE_W'(sw);
         cur_mode = b.draw_mode;
         bar_lim = BAR_W'(int'(b.percent) * int'(vis_w));
         col_n = '0;
         row_n = '0;
         return 1'b0;
      end
      if (spr_w == 0) return 1'b0;
      col = col_n;
      row = row_n;
      col_n = col_n + 1'b1;
      if (col_n >= spr_w) begin
         col_n = '0;
         if (row_n < COUNT_MAX) row_n = row_n + 1'b1;
      end
      if (col < skip_x || col >= skip_x + vis_w || row < skip_y || row >= skip_y + vis_h)
         return 1'b0;
      spr = b.sprite_pixel;
      bg = b.background_pixel;
      vcol = col - int'(skip_x);
      keyed = (spr[KEY_W-1:0] == key);
      case (cur_mode)
         MODE_COPY: pix = spr;
         MODE_KEYED: begin
            if (keyed) return 1'b0;
            pix = spr;
         end
         MODE_TINT: begin
            if (keyed) return 1'b0;
            pix = {bg[31:24], spr[23:16], 1'b0, spr[15:9], 1'b0, spr[7:1]};
         end
         MODE_BLEND: begin
            if (keyed) return 1'b0;
            pix = {bg[31:24], 8'({1'b0, spr[23:17]} + {1'b0, bg[23:17]}),
                   8'({1'b0, spr[15:9]} + {1'b0, bg[15:9]}),
                   8'({1'b0, spr[7:1]} + {1'b0, bg[7:1]})};
         end
         MODE_BAR: begin
            if (keyed) return 1'b0;
            if (int'(BAR_SCALE) * vcol >= int'(bar_lim)) return 1'b0;
            pix = spr;
         end
         default: return 1'b0;
      endcase
      dx = COORD_W'(int'(org_x) + vcol);
      dy = COORD_W'(int'(org_y) + row - int'(skip_y));
      w.dest_x = dx;
      w.dest_y = dy;
      w.dest_offset = OFFSET_W'(longint'(dy) * longint'(pitch) + 4 * longint'(dx));
      w.pixel_out = pix;
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
   endtask

   task automatic compare_write(input string tag, input sbc_rsp_type want,
                                input sbc_rsp_type got);
      if (want.dest_x !== got.dest_x) flag_mismatch({tag, " dest_x"}, want.dest_x, got.dest_x);
      if (want.dest_y !== got.dest_y) flag_mismatch({tag, " dest_y"}, want.dest_y, got.dest_y);
      if (want.dest_offset !== got.dest_offset)
         flag_mismatch({tag, " dest_offset"}, want.dest_offset, got.dest_offset);
      if (want.pixel_out !== got.pixel_out)
         flag_mismatch({tag, " pixel_out"}, want.pixel_out, got.pixel_out);
   endtask

   task automatic send_beat(input sbc_req_type b, output bit hit, output sbc_rsp_type w);
      int n;
      n = draw_wait();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_payload <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      hit = compose_write(b, w);
      if (hit) pending_writes.push_back(w);
      beat_count++;
      if (b.operation == OP_START) start_count++;
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         CSR_CAMERA_X:    cam_x = val[POS_W-1:0];
         CSR_CAMERA_Y:    cam_y = val[POS_W-1:0];
         CSR_DEST_WIDTH:  dst_w = val[DEST_SIDE_W-1:0];
         CSR_DEST_HEIGHT: dst_h = val[DEST_SIDE_W-1:0];
         CSR_DEST_PITCH:  pitch = val[PITCH_W-1:0];
         CSR_COLOR_KEY:   key = val[KEY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input int cx, input int cy, input int w, input int h,
                               input int pt, input logic [KEY_W-1:0] k);
      write_reg(CSR_CAMERA_X, {8'($urandom), 16'(cx)});
      write_reg(CSR_CAMERA_Y, {8'($urandom), 16'(cy)});
      write_reg(CSR_DEST_WIDTH, {11'($urandom), 13'(w)});
      write_reg(CSR_DEST_HEIGHT, {11'($urandom), 13'(h)});
      write_reg(CSR_DEST_PITCH, {8'($urandom), 16'(pt)});
      write_reg(CSR_COLOR_KEY, k);
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   task automatic add_row(input sbc_req_type b, input bit known, input bit writes,
                          input sbc_rsp_type golden);
      script_row_type r;
      r.beat = b;
      r.known = known;
      r.writes = writes;
      r.golden = golden;
      script.push_back(r);
   endtask

   // receiver: stall a random number of cycles before each beat
   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid || reset);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected write to (%0d,%0d), expected none, actual 0x%0h",
                     $time, rsp_payload.dest_x, rsp_payload.dest_y, rsp_payload.pixel_out);
         end else begin
            compare_write("write", pending_writes.pop_front(), rsp_payload);
            write_count++;
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no beat moved for %0d cycles, %0d writes outstanding",
               $time, STALL_LIMIT, pending_writes.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      bit hit;
      sbc_rsp_type w;
      sbc_req_type b;
      logic [191:0] raw;
      int sw, sh, npix, hx, hy, px, py, eff_w, eff_h, budget, phase_base;
      logic [MODE_W-1:0] mode;
      logic [PIXEL_W-1:0] spr;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_row(pixel_beat(32'h1234_5678, 32'h0), 1, 0, '0);
      add_row(start_beat(2, 2, 0, 0, 0, 0, MODE_COPY, 0), 1, 0, '0);
      add_row(pixel_beat(32'hFFFF_FFFF, 32'h0), 1, 1, make_write(0, 0, 0, 32'hFFFF_FFFF));
      add_row(pixel_beat(32'h0000_0000, 32'hFFFF_FFFF), 1, 1, make_write(1, 0, 4, 32'h0));
      add_row(pixel_beat(32'h1234_5678, 32'h0), 1, 1, make_write(0, 1, 2560, 32'h1234_5678));
      add_row(pixel_beat(32'h8000_0001, 32'h0), 1, 1, make_write(1, 1, 2564, 32'h8000_0001));
      add_row(pixel_beat(32'h0055_AA55, 32'h0), 1, 0, '0);
      add_row(start_beat(3, 1, 2, 0, 1, 5, MODE_KEYED, 0), 1, 0, '0);
      add_row(pixel_beat(32'h0011_2233, 32'h0), 1, 0, '0);
      add_row(pixel_beat(32'hFF00_0000, 32'h0), 1, 0, '0);
      add_row(pixel_beat(32'h0100_0001, 32'h0), 1, 1, make_write(1, 5, 12804, 32'h0100_0001));
      add_row(start_beat(1, 1, 0, 0, 10, 20, MODE_TINT, 0), 1, 0, '0);
      add_row(pixel_beat(32'h11FF_8041, 32'hAB00_0000), 1, 1,
              make_write(10, 20, 51240, 32'hABFF_4020));
      add_row(start_beat(1, 1, -3, -7, 0, 0, MODE_BLEND, 0), 1, 0, '0);
      add_row(pixel_beat(32'h00FF_00FE, 32'h7F01_02FF), 1, 1,
              make_write(3, 7, 17932, 32'h7F7F_01FE));
      add_row(start_beat(4, 1, 0, 0, 0, 0, MODE_BAR, 50), 1, 0, '0);
      repeat (4) add_row(pixel_beat($urandom, $urandom), 0, 0, '0);
      add_row(start_beat(1, 1, 0, 0, 0, 0, MODE_UNKNOWN_LAST, 100), 1, 0, '0);
      add_row(pixel_beat(32'h00AB_CDEF, 32'h0), 1, 0, '0);
      add_row(start_beat(0, 5, 0, 0, 0, 0, MODE_COPY, 0), 1, 0, '0);
      add_row(pixel_beat(32'h00AB_CDEF, 32'h0), 1, 0, '0);
      add_row(start_beat(2047, 2047, 32767, -32768, -32768, 32767, MODE_COPY, 127), 1, 0, '0);

      foreach (script[i]) begin
         send_beat(script[i].beat, hit, w);
         if (script[i].known) begin
            if (hit != script[i].writes) flag_mismatch("write present", script[i].writes, hit);
            else if (hit) compare_write("script", script[i].golden, w);
         end
      end

      for (int p = 0; p < 7; p++) begin
         drain_results(12);
         case (p)
            0: program_regs(0, 0, 16, 12, 64, 24'($urandom));
            1: program_regs(-32768, 32767, 4096, 1, 65535, 24'hFF_FFFF);
            2: program_regs(32767, -32768, 8191, 5000, 0, 24'h0);
            3: program_regs(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                            0, $urandom_range(1, 64), $urandom, 24'($urandom));
            4: program_regs($urandom, $urandom, $urandom_range(1, 64), $urandom_range(1, 64),
                            $urandom, 24'($urandom));
            5: program_regs(5, -3, 1, 4096, $urandom, 24'($urandom));
            default: program_regs($urandom, $urandom, $urandom_range(0, 8191),
                                  $urandom_range(1, 16), $urandom, 24'($urandom));
         endcase
         quiet = p[0];
         budget = (p == 3) ? 20 : 56;
         phase_base = beat_count;
         eff_w = (dst_w > MAX_DEST_SIDE) ? MAX_DEST_SIDE : dst_w;
         eff_h = (dst_h > MAX_DEST_SIDE) ? MAX_DEST_SIDE : dst_h;
         while (beat_count - phase_base < budget) begin
            if ($urandom_range(0, 29) == 0) quiet = !quiet;
            if ($urandom_range(0, 24) == 0) drain_results(1);
            if ($urandom_range(0, 9) == 0) begin
               raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
               b = raw[$bits(sbc_req_type)-1:0];
               send_beat(b, hit, w);
            end else begin
               if ($urandom_range(0, 15) == 0) begin
                  sw = $urandom_range(0, 2047);
                  sh = $urandom_range(0, 2047);
                  npix = $urandom_range(0, 20);
               end else begin
                  sw = $urandom_range(1, 8);
                  sh = $urandom_range(1, 6);
                  npix = sw * sh;
                  case ($urandom_range(0, 7))
                     0: npix = npix + int'($urandom_range(1, 3));
                     1: npix = $urandom_range(0, npix - 1);
                     default: ;
                  endcase
               end
               if ($urandom_range(0, 11) == 0)
                  mode = MODE_W'($urandom_range(MODE_BAR + 1, MODE_UNKNOWN_LAST));
               else mode = MODE_W'($urandom_range(MODE_COPY, MODE_BAR));
               hx = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                : int'($urandom_range(0, 16)) - 8;
               hy = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                : int'($urandom_range(0, 16)) - 8;
               px = int'(cam_x) + ($urandom_range(0, 1) ? 0 : eff_w - sw)
                    + int'($urandom_range(0, 12)) - 6;
               py = int'(cam_y) + ($urandom_range(0, 1) ? 0 : eff_h - sh)
                    + int'($urandom_range(0, 12)) - 6;
               send_beat(start_beat(sw, sh, hx, hy, px + hx, py + hy, mode,
                                    $urandom_range(0, 127)), hit, w);
               repeat (npix) begin
                  spr = ($urandom_range(0, 3) == 0) ? {8'($urandom), key} : 32'($urandom);
                  send_beat(pixel_beat(spr, $urandom), hit, w);
               end
            end
         end
      end

      drain_results(12);
      $display("Sent %0d beats (%0d draw commands) across %0d window settings.",
               beat_count, start_count, setting_count);
      $display("Compared %0d pixel writes; %0d mismatches.", write_count, error_count);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_queue.sv
hw/rtl/sbc_front.sv
hw/rtl/sbc_back.sv
hw/rtl/sprite_blit_compositor_unit.sv
hw/rtl/sbc_checker.sv
tb/sv/tb_top.sv
